// ----- rtl/vt_pkg.sv -----
// ----------------------------------------------------------------------------
// vt_pkg
// Shared codes and pipeline side-band type for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt_pkg;

  // Operation codes carried on the mode field
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_VEC   = 2'd1;
  localparam logic [1:0] MODE_POINT = 2'd2;

  // Side-band that travels with each beat through the divide stages
  typedef struct packed {
    logic             valid;
    logic             point;
    logic             dz;
    logic             ovf;
    logic [2:0]       neg;
    logic [31:0]      dm;
    logic [3:0][31:0] res;
  } side_t;

endpackage

// ----- rtl/vertex_transform_4x4.sv -----
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Q-format 4x4 matrix times vector, with optional perspective divide.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  input   | in_mode, in_elem_*, in_vx..in_vw        | in_valid / in_ready
//  result  | out_rx..out_rw, out_overflow, out_div_zero | out_valid / out_ready
//
// One beat enters per cycle while the output is not stalled; the
// restoring divider resolves one quotient bit per stage.
// Reset loads the identity matrix and empties the pipeline.
// A stalled output freezes every stage; in_ready = !out_valid | out_ready.
// Matrix loads take effect for the next beat accepted.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [3:0]         in_elem_index,
  input  logic signed [31:0] in_elem_value,
  input  logic signed [31:0] in_vx,
  input  logic signed [31:0] in_vy,
  input  logic signed [31:0] in_vz,
  input  logic signed [31:0] in_vw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rx,
  output logic signed [31:0] out_ry,
  output logic signed [31:0] out_rz,
  output logic signed [31:0] out_rw,
  output logic               out_overflow,
  output logic               out_div_zero
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int SW = 66;
  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SMIN = -SW'(64'sd2147483648);
  localparam logic [DW-1:0] QMAXP = DW'(64'd2147483647);
  localparam logic [DW-1:0] QMAXN = DW'(64'd2147483648);

  logic en;
  logic in_fire;
  logic signed [31:0] mat_r [16];
  logic signed [31:0] vec [4];

  logic va_r, pa_r;
  logic signed [63:0] prod_r [16];
  logic vb_r, pb_r;
  logic signed [SW-1:0] sum_r [4];
  logic vc_r, pc_r, oc_r;
  logic signed [31:0] resc_r [4];

  vt_pkg::side_t side_r [DW+1];
  logic [31:0]   rem_r  [DW+1][3];
  logic [DW-1:0] qd_r   [DW+1][3];

  logic out_valid_r;
  logic signed [31:0] out_rx_r, out_ry_r, out_rz_r, out_rw_r;
  logic out_ovf_r, out_dz_r;

  // Global advance: move when the output slot is free or being taken
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  // Pick the vector, point mode forces w to one
  always_comb begin
    vec[0] = in_vx;
    vec[1] = in_vy;
    vec[2] = in_vz;
    vec[3] = (in_mode == vt_pkg::MODE_POINT) ? $signed(ONE) : in_vw;
  end

  // Matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= (i % 5 == 0) ? $signed(ONE) : '0;
    end else if (in_fire && in_mode == vt_pkg::MODE_LOAD) begin
      mat_r[in_elem_index] <= in_elem_value;
    end
  end

  // Stage A: sixteen products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid && (in_mode == vt_pkg::MODE_VEC || in_mode == vt_pkg::MODE_POINT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= (in_mode == vt_pkg::MODE_POINT);
      for (int i = 0; i < 16; i++) prod_r[i] <= mat_r[i] * vec[i % 4];
    end
  end

  // Stage B: exact row sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb_r <= pa_r;
      for (int r = 0; r < 4; r++) begin
        sum_r[r] <= SW'(prod_r[4*r]) + SW'(prod_r[4*r+1])
                  + SW'(prod_r[4*r+2]) + SW'(prod_r[4*r+3]);
      end
    end
  end

  // Stage C: scale down with floor, saturate
  logic signed [SW-1:0] sh [4];
  logic signed [31:0]   resc_nxt [4];
  logic                 oc_nxt;

  always_comb begin
    oc_nxt = 1'b0;
    for (int r = 0; r < 4; r++) begin
      sh[r] = sum_r[r] >>> FRAC_BITS;
      if (sh[r] > SMAX) begin
        resc_nxt[r] = 32'sh7fffffff;
        oc_nxt      = 1'b1;
      end else if (sh[r] < SMIN) begin
        resc_nxt[r] = 32'sh80000000;
        oc_nxt      = 1'b1;
      end else begin
        resc_nxt[r] = sh[r][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r <= pb_r;
      oc_r <= oc_nxt;
      for (int r = 0; r < 4; r++) resc_r[r] <= resc_nxt[r];
    end
  end

  // Divider setup: magnitudes and signs
  vt_pkg::side_t side_nxt;
  logic [31:0]   mag [3];

  always_comb begin
    side_nxt.valid = vc_r;
    side_nxt.point = pc_r;
    side_nxt.dz    = pc_r && (resc_r[3] == '0);
    side_nxt.ovf   = oc_r;
    side_nxt.dm    = resc_r[3][31] ? 32'(-resc_r[3]) : resc_r[3];
    for (int r = 0; r < 4; r++) side_nxt.res[r] = resc_r[r];
    for (int i = 0; i < 3; i++) begin
      side_nxt.neg[i] = resc_r[i][31] ^ resc_r[3][31];
      mag[i]          = resc_r[i][31] ? 32'(-resc_r[i]) : resc_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0] <= '0;
    end else if (en) begin
      side_r[0] <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= '0;
        qd_r[0][i]  <= DW'(mag[i]) << FRAC_BITS;
      end
    end
  end

  // Restoring divide, one quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [32:0]   trial [3];
    logic          ge    [3];
    logic [32:0]   diff  [3];
    logic [31:0]   rem_nxt [3];
    logic [DW-1:0] qd_nxt  [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i]   = {rem_r[k][i], qd_r[k][i][DW-1]};
        ge[i]      = trial[i] >= {1'b0, side_r[k].dm};
        diff[i]    = trial[i] - {1'b0, side_r[k].dm};
        rem_nxt[i] = ge[i] ? diff[i][31:0] : trial[i][31:0];
        qd_nxt[i]  = {qd_r[k][i][DW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k+1] <= '0;
      end else if (en) begin
        side_r[k+1] <= side_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem_r[k+1][i] <= rem_nxt[i];
          qd_r[k+1][i]  <= qd_nxt[i];
        end
      end
    end
  end

  // Output stage: sign, saturate, select by mode, clear on divide by zero
  vt_pkg::side_t fin;
  logic signed [31:0] quo [3];
  logic signed [31:0] res_nxt [4];
  logic               ovf_nxt;
  logic               dz_nxt;

  always_comb begin
    fin     = side_r[DW];
    ovf_nxt = fin.ovf;
    dz_nxt  = fin.dz;
    for (int i = 0; i < 3; i++) begin
      if (!fin.neg[i] && qd_r[DW][i] > QMAXP) begin
        quo[i] = 32'sh7fffffff;
        if (fin.point) ovf_nxt = 1'b1;
      end else if (fin.neg[i] && qd_r[DW][i] > QMAXN) begin
        quo[i] = 32'sh80000000;
        if (fin.point) ovf_nxt = 1'b1;
      end else begin
        quo[i] = fin.neg[i] ? -$signed(qd_r[DW][i][31:0]) : $signed(qd_r[DW][i][31:0]);
      end
    end
    for (int r = 0; r < 4; r++) res_nxt[r] = fin.res[r];
    if (fin.point) begin
      for (int i = 0; i < 3; i++) res_nxt[i] = quo[i];
    end
    if (fin.dz) begin
      ovf_nxt = 1'b0;
      for (int r = 0; r < 4; r++) res_nxt[r] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rx_r  <= res_nxt[0];
      out_ry_r  <= res_nxt[1];
      out_rz_r  <= res_nxt[2];
      out_rw_r  <= res_nxt[3];
      out_ovf_r <= ovf_nxt;
      out_dz_r  <= dz_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rx       = out_rx_r;
  assign out_ry       = out_ry_r;
  assign out_rz       = out_rz_r;
  assign out_rw       = out_rw_r;
  assign out_overflow = out_ovf_r;
  assign out_div_zero = out_dz_r;

  // Checks
  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> !out_overflow && out_rx == '0 && out_rw == '0)
    else $error("divide-by-zero beat not cleared");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready out of step with output slot");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == vt_pkg::MODE_LOAD
    |=> mat_r[$past(in_elem_index)] == $past(in_elem_value))
    else $error("matrix load lost");

endmodule
